// ----- hdl/mfap_pkg.sv -----
// Shared types and constants for the max-flow block.
// Holds controller/datapath command and status structs; no dependencies.
package mfap_pkg;

  localparam int NODE_W    = 7;   // width of node numbers on the ports
  localparam int EDGE_CAP_W = 16; // width of an incoming edge capacity
  localparam int CAP_W     = 24;  // saturating capacity cell
  localparam int RES_W     = 25;  // residual cell: cap(u,v) + cap(v,u) fits
  localparam int FLOW_W    = 32;

  localparam logic [CAP_W-1:0]  CAP_MAX       = '1;
  localparam logic [NODE_W-1:0] NUM_NODES_RST = 7'd64;

  typedef enum logic [4:0] {
    OP_NOP       = 5'd0,
    OP_IDLE      = 5'd1,
    OP_BFS_INIT  = 5'd2,
    OP_DEQ       = 5'd3,
    OP_DEQW      = 5'd4,
    OP_SCAN      = 5'd5,
    OP_AU_CLR    = 5'd6,
    OP_AUG_READ  = 5'd7,
    OP_AU_INC    = 5'd8,
    OP_AUG_LOAD  = 5'd9,
    OP_WALK_P    = 5'd10,
    OP_WALK_R    = 5'd11,
    OP_UPD_START = 5'd12,
    OP_UPD_A     = 5'd13,
    OP_UPD_B     = 5'd14,
    OP_UPD_P     = 5'd15,
    OP_FINISH    = 5'd16,
    OP_CLEAR     = 5'd17
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic deq_empty;
    logic deq_is_sink;
    logic scan_last;
    logic sink_visited;
    logic aug_done;
    logic aug_skip;
    logic au_root;
    logic wp_root;
    logic low_zero;
    logic out_free;
    logic clr_last;
  } stat_t;

endpackage

// ----- hdl/mfap_ctrl.sv -----
// Sequencer for the max-flow block: loading, BFS, augmentation, clearing.
// Depends on mfap_pkg; drives commands to mfap_dp and reads its status.
module mfap_ctrl import mfap_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  last_edge,
  output logic  in_stall,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [17:0] {
    S_IDLE      = 18'b000000000000000001,
    S_BFS_INIT  = 18'b000000000000000010,
    S_DEQ       = 18'b000000000000000100,
    S_DEQW      = 18'b000000000000001000,
    S_SCAN      = 18'b000000000000010000,
    S_SCAN_END  = 18'b000000000000100000,
    S_CHECK     = 18'b000000000001000000,
    S_AUG_NEXT  = 18'b000000000010000000,
    S_AUG_RD    = 18'b000000000100000000,
    S_WALK_P    = 18'b000000001000000000,
    S_WALK_R    = 18'b000000010000000000,
    S_LOWCHK    = 18'b000000100000000000,
    S_UPD_START = 18'b000001000000000000,
    S_UPD_A     = 18'b000010000000000000,
    S_UPD_B     = 18'b000100000000000000,
    S_UPD_P     = 18'b001000000000000000,
    S_FINISH    = 18'b010000000000000000,
    S_CLEAR     = 18'b100000000000000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    unique case (state)
      S_IDLE: begin
        cmd.op = OP_IDLE;
        if (in_valid && last_edge) state_next = S_BFS_INIT;
      end
      S_BFS_INIT: begin
        cmd.op     = OP_BFS_INIT;
        state_next = S_DEQ;
      end
      S_DEQ: begin
        if (stat.deq_empty) begin
          state_next = S_CHECK;
        end else begin
          cmd.op     = OP_DEQ;
          state_next = S_DEQW;
        end
      end
      S_DEQW: begin
        cmd.op     = OP_DEQW;
        state_next = stat.deq_is_sink ? S_DEQ : S_SCAN;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_last) state_next = S_SCAN_END;
      end
      S_SCAN_END: state_next = S_DEQ;   // last discovery lands here
      S_CHECK: begin
        cmd.op     = OP_AU_CLR;
        state_next = stat.sink_visited ? S_AUG_NEXT : S_FINISH;
      end
      S_AUG_NEXT: begin
        if (stat.aug_done) begin
          state_next = S_BFS_INIT;
        end else begin
          cmd.op     = OP_AUG_READ;
          state_next = S_AUG_RD;
        end
      end
      S_AUG_RD: begin
        if (stat.aug_skip) begin
          cmd.op     = OP_AU_INC;
          state_next = S_AUG_NEXT;
        end else begin
          cmd.op     = OP_AUG_LOAD;
          state_next = stat.au_root ? S_LOWCHK : S_WALK_P;
        end
      end
      S_WALK_P: begin
        cmd.op     = OP_WALK_P;
        state_next = S_WALK_R;
      end
      S_WALK_R: begin
        cmd.op     = OP_WALK_R;
        state_next = stat.wp_root ? S_LOWCHK : S_WALK_P;
      end
      S_LOWCHK: begin
        if (stat.low_zero) begin
          cmd.op     = OP_AU_INC;
          state_next = S_AUG_NEXT;
        end else begin
          state_next = S_UPD_START;
        end
      end
      S_UPD_START: begin
        cmd.op     = OP_UPD_START;
        state_next = S_UPD_A;
      end
      S_UPD_A: begin
        cmd.op     = OP_UPD_A;
        state_next = S_UPD_B;
      end
      S_UPD_B: begin
        cmd.op     = OP_UPD_B;
        state_next = stat.wp_root ? S_AUG_NEXT : S_UPD_P;
      end
      S_UPD_P: begin
        cmd.op     = OP_UPD_P;
        state_next = S_UPD_A;
      end
      S_FINISH: begin
        cmd.op = OP_FINISH;
        if (stat.out_free) state_next = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/mfap_dp.sv -----
// Datapath for the max-flow block: residual store, BFS queue, parent store,
// counters and result register. Depends on mfap_pkg; driven by mfap_ctrl.
module mfap_dp import mfap_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic                  cfg_write,
  input  logic [NODE_W-1:0]     cfg_data,
  input  logic                  in_valid,
  input  logic [NODE_W-1:0]     from_node,
  input  logic [NODE_W-1:0]     to_node,
  input  logic [EDGE_CAP_W-1:0] edge_capacity,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [FLOW_W-1:0]     max_flow
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int AW    = 2 * NW;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = NW + 1;

  logic [NODE_W-1:0] num_nodes;
  logic [NW-1:0]     sink;
  logic              in_range;
  logic              accept;

  // residual store: cap(u,v) - flow(u,v), addressed {u, v}
  logic [RES_W-1:0] res_mem [DEPTH];
  logic [RES_W-1:0] rdata;
  logic [AW-1:0]    raddr, waddr;
  logic [RES_W-1:0] wdata;
  logic             we;

  logic [NW-1:0] q_mem [MAX_NODES];
  logic [NW-1:0] p_mem [MAX_NODES];
  logic [NW-1:0] q_rdata, p_rdata, p_raddr, q_waddr, q_wdata;
  logic          q_we;

  logic [MAX_NODES-1:0] visited;
  logic [CW-1:0]        head, tail;
  logic [NW-1:0]        u_cur, scan_v, sc_v, au, wv, wp;
  logic                 sc_valid, disc;
  logic [RES_W-1:0]     low, low_min;
  logic [FLOW_W-1:0]    total;
  logic [AW-1:0]        clr;

  // load pipeline with forwarding from the previous load write for repeated edges
  logic             ld_valid;
  logic [AW-1:0]    ld_addr;
  logic [EDGE_CAP_W-1:0] ld_cap;
  logic             wr_prev_valid;
  logic [AW-1:0]    wr_prev_addr;
  logic [RES_W-1:0] wr_prev_data, ld_base, ld_wdata;
  logic [RES_W:0]   ld_sum;

  always_comb begin
    if (int'(num_nodes) < 2) begin
      sink = NW'(1);
    end else if (int'(num_nodes) > MAX_NODES) begin
      sink = NW'(MAX_NODES - 1);
    end else begin
      sink = NW'(num_nodes - NODE_W'(1));
    end
  end

  assign in_range = (from_node != '0) && (int'(from_node) <= int'(sink) + 1) &&
                    (to_node != '0) && (int'(to_node) <= int'(sink) + 1);
  assign accept   = (cmd.op == OP_IDLE) && in_valid;

  assign ld_base  = (wr_prev_valid && wr_prev_addr == ld_addr) ? wr_prev_data : rdata;
  assign ld_sum   = {1'b0, ld_base} + {{(RES_W + 1 - EDGE_CAP_W){1'b0}}, ld_cap};
  assign ld_wdata = (ld_sum > {{(RES_W + 1 - CAP_W){1'b0}}, CAP_MAX}) ?
                    {{(RES_W - CAP_W){1'b0}}, CAP_MAX} : ld_sum[RES_W-1:0];

  assign low_min = (rdata < low) ? rdata : low;
  assign disc    = sc_valid && !visited[sc_v] && (rdata != '0);

  always_comb begin
    raddr = '0;
    unique case (cmd.op)
      OP_IDLE:                 raddr = {NW'(from_node - NODE_W'(1)),
                                        NW'(to_node - NODE_W'(1))};
      OP_SCAN:                 raddr = {u_cur, scan_v};
      OP_AUG_READ,
      OP_UPD_START:            raddr = {au, sink};
      OP_WALK_P, OP_UPD_P:     raddr = {p_rdata, wv};
      OP_UPD_A:                raddr = {wv, wp};
      default:                 raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    priority if (ld_valid) begin
      we    = 1'b1;
      waddr = ld_addr;
      wdata = ld_wdata;
    end else if (cmd.op == OP_UPD_A) begin
      we    = 1'b1;
      waddr = {wp, wv};
      wdata = rdata - low;
    end else if (cmd.op == OP_UPD_B) begin
      we    = 1'b1;
      waddr = {wv, wp};
      wdata = rdata + low;
    end else if (cmd.op == OP_CLEAR) begin
      we    = 1'b1;
      waddr = clr;
    end
  end

  always_ff @(posedge clk) begin
    if (we) res_mem[waddr] <= wdata;
    rdata <= res_mem[raddr];
  end

  // queue and parent stores
  assign q_we    = (cmd.op == OP_BFS_INIT) || disc;
  assign q_waddr = (cmd.op == OP_BFS_INIT) ? '0 : tail[NW-1:0];
  assign q_wdata = (cmd.op == OP_BFS_INIT) ? '0 : sc_v;
  assign p_raddr = (cmd.op == OP_AUG_LOAD) ? au : wp;

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_rdata <= q_mem[head[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (disc) p_mem[sc_v] <= u_cur;
    p_rdata <= p_mem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_nodes     <= NUM_NODES_RST;
      ld_valid      <= 1'b0;
      wr_prev_valid <= 1'b0;
      sc_valid      <= 1'b0;
      out_valid     <= 1'b0;
      clr           <= '0;
      total         <= '0;
    end else begin
      if (cfg_write) num_nodes <= cfg_data;
      ld_valid      <= accept && in_range;
      wr_prev_valid <= ld_valid;
      sc_valid      <= (cmd.op == OP_SCAN);
      if (cmd.op == OP_FINISH && stat.out_free) begin
        out_valid <= 1'b1;
        total     <= '0;
        clr       <= '0;
      end else begin
        if (out_valid && !out_stall) out_valid <= 1'b0;
        if (cmd.op == OP_CLEAR) clr <= clr + AW'(1);
        if (cmd.op == OP_UPD_B && wp == '0)
          total <= total + {{(FLOW_W - RES_W){1'b0}}, low};
      end
    end
  end

  always_ff @(posedge clk) begin
    ld_addr      <= {NW'(from_node - NODE_W'(1)), NW'(to_node - NODE_W'(1))};
    ld_cap       <= edge_capacity;
    wr_prev_addr <= ld_addr;
    wr_prev_data <= ld_wdata;
    sc_v         <= scan_v;
    if (cmd.op == OP_FINISH && stat.out_free) max_flow <= total;

    if (disc) begin
      visited[sc_v] <= 1'b1;
      tail          <= tail + CW'(1);
    end

    unique case (cmd.op)
      OP_BFS_INIT: begin
        visited <= MAX_NODES'(1);
        head    <= '0;
        tail    <= CW'(1);
      end
      OP_DEQ:       head   <= head + CW'(1);
      OP_DEQW: begin
        u_cur  <= q_rdata;
        scan_v <= '0;
      end
      OP_SCAN:      scan_v <= scan_v + NW'(1);
      OP_AU_CLR:    au     <= '0;
      OP_AU_INC:    au     <= au + NW'(1);
      OP_AUG_LOAD: begin
        low <= rdata;
        wv  <= au;
      end
      OP_WALK_P:    wp <= p_rdata;
      OP_WALK_R: begin
        low <= low_min;
        wv  <= wp;
      end
      OP_UPD_START: begin
        wv <= sink;
        wp <= au;
      end
      OP_UPD_B: begin
        if (wp == '0) au <= au + NW'(1);
        else          wv <= wp;
      end
      OP_UPD_P:     wp <= p_rdata;
      default: ;
    endcase
  end

  always_comb begin
    stat.deq_empty    = (head == tail);
    stat.deq_is_sink  = (q_rdata == sink);
    stat.scan_last    = (scan_v == sink);
    stat.sink_visited = visited[sink];
    stat.aug_done     = (au == sink);
    stat.aug_skip     = !visited[au] || (rdata == '0);
    stat.au_root      = (au == '0);
    stat.wp_root      = (wp == '0);
    stat.low_zero     = (low == '0);
    stat.out_free     = !out_valid || !out_stall;
    stat.clr_last     = &clr;
  end

endmodule

// ----- hdl/max_flow_augmenting_paths_top.sv -----
// Maximum flow (shortest augmenting paths) from node 1 to node num_nodes.
// Edges load at one transfer per cycle while in_stall is low; repeated
// edges add, saturating at 2^24-1. After the edge flagged last, the block
// repeats breadth-first searches and walks each augmenting path to measure
// and then to update it, all bound by the single read port of the residual
// store. After every result, and after reset, the residual store is cleared
// one word a cycle, MAX_NODES rounded up to a power of two and then squared
// words in all (4096 at 64 nodes), during which no edge is taken. The user
// must write num_nodes only while the block is idle; the block itself
// does not enforce this. Depends on mfap_pkg, mfap_ctrl and mfap_dp.
module max_flow_augmenting_paths_top import mfap_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [NODE_W-1:0]     cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [NODE_W-1:0]     from_node,
  input  logic [NODE_W-1:0]     to_node,
  input  logic [EDGE_CAP_W-1:0] edge_capacity,
  input  logic                  last_edge,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FLOW_W-1:0]     max_flow
);

  cmd_t  cmd;
  stat_t stat;

  mfap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_edge (last_edge),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  mfap_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .from_node     (from_node),
    .to_node       (to_node),
    .edge_capacity (edge_capacity),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .max_flow      (max_flow)
  );

endmodule
